// ----- rtl/upac_pkg.sv -----
package upac_pkg;

  localparam int ADDR_W      = 32;
  localparam int PAGE_W      = 20;
  localparam int PAGE_SHIFT  = 12;
  localparam int SLOT_W      = 4;
  localparam int STACK_SLOTS = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  localparam logic [ADDR_W-1:0] USER_START_RST = 32'h0010_0000;
  localparam logic [PAGE_W-1:0] CODE_END_RST   = 20'd264;
  localparam logic [PAGE_W-1:0] GLOBAL_END_RST = 20'd276;
  localparam logic [PAGE_W-1:0] AUX_PAGE_RST   = 20'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USER_START = 2'd0,
    REG_CODE_END   = 2'd1,
    REG_GLOBAL_END = 2'd2,
    REG_AUX_PAGE   = 2'd3
  } cfg_reg_t;

  // one transaction moving down the chain, either a check or a table load
  typedef struct packed {
    logic              is_check;
    logic              is_write;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic              decided;
    logic              allowed;
    logic              wr_pending;
    logic [SLOT_W-1:0] slot_left;
    logic              slot_live;
    logic [PAGE_W-1:0] lo_page;
    logic [PAGE_W-1:0] hi_page;
  } token_t;

  function automatic logic [ADDR_W-1:0] page_base(input logic [PAGE_W-1:0] page);
    return {page, {PAGE_SHIFT{1'b0}}};
  endfunction

endpackage

// ----- rtl/upac_front.sv -----
module upac_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [upac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [upac_pkg::ADDR_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic                          is_write,
  input  logic [upac_pkg::ADDR_W-1:0]   address,
  input  logic [upac_pkg::ADDR_W-1:0]   length,
  input  logic [upac_pkg::SLOT_W-1:0]   slot,
  input  logic                          slot_active,
  input  logic [upac_pkg::PAGE_W-1:0]   stack_first_page,
  input  logic [upac_pkg::PAGE_W-1:0]   stack_page_count,
  output logic                          dn_valid,
  output upac_pkg::token_t              dn_tok,
  input  logic                          dn_ready
);

  logic [upac_pkg::ADDR_W-1:0] region_base;
  logic [upac_pkg::PAGE_W-1:0] code_limit;
  logic [upac_pkg::PAGE_W-1:0] region_limit;
  logic [upac_pkg::PAGE_W-1:0] aux_page;

  logic             s1_valid;
  upac_pkg::token_t s1_tok;
  upac_pkg::token_t s1_tok_next;
  upac_pkg::token_t s2_tok_next;
  logic             s1_ready;
  logic [upac_pkg::ADDR_W:0] sum;
  logic [upac_pkg::PAGE_W-1:0] aux_end;
  logic in_global;
  logic in_aux;
  logic below_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= upac_pkg::USER_START_RST;
      code_limit   <= upac_pkg::CODE_END_RST;
      region_limit <= upac_pkg::GLOBAL_END_RST;
      aux_page     <= upac_pkg::AUX_PAGE_RST;
    end else if (cfg_write) begin
      unique case (upac_pkg::cfg_reg_t'(cfg_index))
        upac_pkg::REG_USER_START: region_base  <= cfg_data;
        upac_pkg::REG_CODE_END:   code_limit   <= cfg_data[upac_pkg::PAGE_W-1:0];
        upac_pkg::REG_GLOBAL_END: region_limit <= cfg_data[upac_pkg::PAGE_W-1:0];
        upac_pkg::REG_AUX_PAGE:   aux_page     <= cfg_data[upac_pkg::PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: end address with carry, slot bounds precomputed as pages
  always_comb begin
    sum = {1'b0, address} + {1'b0, length};
    s1_tok_next            = '0;
    s1_tok_next.is_check   = (op == upac_pkg::OP_CHECK);
    s1_tok_next.is_write   = is_write;
    s1_tok_next.start      = address;
    s1_tok_next.stop       = sum[upac_pkg::ADDR_W-1:0];
    s1_tok_next.decided    = (op == upac_pkg::OP_CHECK) && sum[upac_pkg::ADDR_W];
    s1_tok_next.allowed    = 1'b0;
    s1_tok_next.wr_pending = (op == upac_pkg::OP_TABLE);
    s1_tok_next.slot_left  = slot;
    s1_tok_next.slot_live  = slot_active && (stack_first_page != '0);
    s1_tok_next.lo_page    = stack_first_page;
    s1_tok_next.hi_page    = stack_first_page + stack_page_count;
  end

  // stage 2: global region and aux stack page
  always_comb begin
    aux_end    = aux_page + upac_pkg::PAGE_W'(1);
    in_global  = (s1_tok.start >= region_base) &&
                 (s1_tok.stop <= upac_pkg::page_base(region_limit));
    in_aux     = (s1_tok.start >= upac_pkg::page_base(aux_page)) &&
                 (s1_tok.stop <= upac_pkg::page_base(aux_end));
    below_code = s1_tok.start < upac_pkg::page_base(code_limit);
    s2_tok_next = s1_tok;
    if (s1_tok.is_check && !s1_tok.decided) begin
      if (in_global) begin
        s2_tok_next.decided = 1'b1;
        s2_tok_next.allowed = !(s1_tok.is_write && below_code);
      end else if (in_aux) begin
        s2_tok_next.decided = 1'b1;
        s2_tok_next.allowed = 1'b1;
      end
    end
  end

  assign s1_ready = !dn_valid || dn_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_ready) dn_valid <= s1_valid;
    end
    if (in_ready) s1_tok <= s1_tok_next;
    if (s1_ready) dn_tok <= s2_tok_next;
  end

endmodule

// ----- rtl/upac_cell.sv -----
module upac_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  upac_pkg::token_t up_tok,
  output logic             up_ready,
  output logic             dn_valid,
  output upac_pkg::token_t dn_tok,
  input  logic             dn_ready
);

  logic                        live;
  logic [upac_pkg::PAGE_W-1:0] lo_page;
  logic [upac_pkg::PAGE_W-1:0] hi_page;
  logic                        table_hit;
  logic                        range_hit;
  upac_pkg::token_t            tok_next;

  // a load is addressed here once its countdown reaches zero
  assign table_hit = !up_tok.is_check && up_tok.wr_pending && (up_tok.slot_left == '0);
  assign range_hit = live &&
                     (up_tok.start >= upac_pkg::page_base(lo_page)) &&
                     (up_tok.stop <= upac_pkg::page_base(hi_page));
  assign up_ready  = !dn_valid || dn_ready;

  always_comb begin
    tok_next = up_tok;
    if (up_tok.is_check) begin
      if (!up_tok.decided && range_hit) begin
        tok_next.decided = 1'b1;
        tok_next.allowed = 1'b1;
      end
    end else if (table_hit) begin
      tok_next.wr_pending = 1'b0;
    end else begin
      tok_next.slot_left = up_tok.slot_left - upac_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
      live     <= 1'b0;
    end else begin
      if (up_ready) dn_valid <= up_valid;
      if (up_ready && up_valid && table_hit) live <= up_tok.slot_live;
    end
    if (up_ready) dn_tok <= tok_next;
    if (up_ready && up_valid && table_hit) begin
      lo_page <= up_tok.lo_page;
      hi_page <= up_tok.hi_page;
    end
  end

`ifndef SYNTHESIS
  a_load_lands: assert property (@(posedge clk) disable iff (rst)
    (up_ready && up_valid && table_hit) |=>
      (live == $past(up_tok.slot_live)) && !dn_tok.wr_pending)
    else $error("table load did not land in its slot");

  a_verdict_kept: assert property (@(posedge clk) disable iff (rst)
    (up_ready && up_valid && up_tok.is_check && up_tok.decided) |=>
      dn_valid && dn_tok.decided && (dn_tok.allowed == $past(up_tok.allowed)))
    else $error("decided check changed its verdict");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && !dn_ready) |=> dn_valid && $stable(dn_tok))
    else $error("stalled transaction moved");
`endif

endmodule

// ----- rtl/user_pointer_access_checker_top.sv -----
// channel  direction  handshake               payload
// cfg      in         cfg_write               cfg_index, cfg_data
// in       in         in_valid / in_stall     op, is_write, address, length, slot,
//                                             slot_active, stack_first_page, stack_page_count
// out      out        out_valid / out_stall   allowed
//
// one transaction per cycle sustained while out_stall is low; the pipe has two front stages,
// one cell per stack slot (16), one output register
// table loads travel the chain in order with checks and give no result
// reset clears config to defaults, all slots to inactive and all stages to empty
// each stage holds while the one below is full and stalled, so stalls ripple back
module user_pointer_access_checker_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [upac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [upac_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic                           is_write,
  input  logic [upac_pkg::ADDR_W-1:0]    address,
  input  logic [upac_pkg::ADDR_W-1:0]    length,
  input  logic [upac_pkg::SLOT_W-1:0]    slot,
  input  logic                           slot_active,
  input  logic [upac_pkg::PAGE_W-1:0]    stack_first_page,
  input  logic [upac_pkg::PAGE_W-1:0]    stack_page_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           allowed
);

  logic             chain_valid [upac_pkg::STACK_SLOTS+1];
  upac_pkg::token_t chain_tok   [upac_pkg::STACK_SLOTS+1];
  logic             chain_ready [upac_pkg::STACK_SLOTS+1];
  logic             in_ready;

  assign in_stall = !in_ready;

  upac_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .is_write         (is_write),
    .address          (address),
    .length           (length),
    .slot             (slot),
    .slot_active      (slot_active),
    .stack_first_page (stack_first_page),
    .stack_page_count (stack_page_count),
    .dn_valid         (chain_valid[0]),
    .dn_tok           (chain_tok[0]),
    .dn_ready         (chain_ready[0])
  );

  for (genvar i = 0; i < upac_pkg::STACK_SLOTS; i++) begin : g_cell
    upac_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_tok   (chain_tok[i]),
      .up_ready (chain_ready[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_tok   (chain_tok[i+1]),
      .dn_ready (chain_ready[i+1])
    );
  end

  // table loads are dropped here, checks become results
  assign chain_ready[upac_pkg::STACK_SLOTS] = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[upac_pkg::STACK_SLOTS]) begin
      out_valid <= chain_valid[upac_pkg::STACK_SLOTS] &&
                   chain_tok[upac_pkg::STACK_SLOTS].is_check;
    end
    if (chain_ready[upac_pkg::STACK_SLOTS]) begin
      allowed <= chain_tok[upac_pkg::STACK_SLOTS].decided &&
                 chain_tok[upac_pkg::STACK_SLOTS].allowed;
    end
  end

endmodule

// ----- dv/user_pointer_access_checker_top_tb.sv -----
module user_pointer_access_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 220;

  typedef struct {
    logic                        op;
    logic                        is_write;
    logic [upac_pkg::ADDR_W-1:0] address;
    logic [upac_pkg::ADDR_W-1:0] length;
    logic [upac_pkg::SLOT_W-1:0] slot;
    logic                        slot_active;
    logic [upac_pkg::PAGE_W-1:0] stack_first_page;
    logic [upac_pkg::PAGE_W-1:0] stack_page_count;
  } access_req_t;

  typedef struct {
    logic                        active;
    logic [upac_pkg::PAGE_W-1:0] first_page;
    logic [upac_pkg::PAGE_W-1:0] page_count;
  } stack_slot_t;

  logic                        clk              = 1'b0;
  logic                        rst              = 1'b1;
  logic                        cfg_write        = 1'b0;
  upac_pkg::cfg_reg_t          cfg_index        = upac_pkg::REG_USER_START;
  logic [upac_pkg::ADDR_W-1:0] cfg_data         = '0;
  logic                        in_valid         = 1'b0;
  logic                        in_stall;
  logic                        op               = upac_pkg::OP_CHECK;
  logic                        is_write         = 1'b0;
  logic [upac_pkg::ADDR_W-1:0] address          = '0;
  logic [upac_pkg::ADDR_W-1:0] length           = '0;
  logic [upac_pkg::SLOT_W-1:0] slot             = '0;
  logic                        slot_active      = 1'b0;
  logic [upac_pkg::PAGE_W-1:0] stack_first_page = '0;
  logic [upac_pkg::PAGE_W-1:0] stack_page_count = '0;
  logic                        out_valid;
  logic                        out_stall        = 1'b0;
  logic                        allowed;

  // predictor state
  logic [upac_pkg::ADDR_W-1:0] cfg_region_base  = upac_pkg::USER_START_RST;
  logic [upac_pkg::PAGE_W-1:0] cfg_code_limit   = upac_pkg::CODE_END_RST;
  logic [upac_pkg::PAGE_W-1:0] cfg_region_limit = upac_pkg::GLOBAL_END_RST;
  logic [upac_pkg::PAGE_W-1:0] cfg_aux_page     = upac_pkg::AUX_PAGE_RST;
  stack_slot_t                 stack_slots_m [upac_pkg::STACK_SLOTS];
  logic                        allowed_q [$];

  int error_count  = 0;
  int burst_left   = 0;
  bit no_gaps      = 1'b0;
  bit hold_req     = 1'b0;
  int quiet_cycles = 0;

  user_pointer_access_checker_top i_dut (.*);

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [upac_pkg::ADDR_W-1:0] page_addr(input logic [31:0] pg);
    return pg << upac_pkg::PAGE_SHIFT;
  endfunction

  function automatic logic fits(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] lo, input logic [31:0] hi);
    return (a >= lo) && (b <= hi);
  endfunction

  function automatic logic predict_allowed(input logic wr, input logic [31:0] start,
                                           input logic [31:0] len);
    logic [32:0] sum;
    logic [31:0] stop;
    logic [31:0] lo;
    logic [31:0] hi;
    sum  = {1'b0, start} + {1'b0, len};
    stop = sum[31:0];
    if (sum[32]) return 1'b0;
    if (fits(start, stop, cfg_region_base, page_addr(32'(cfg_region_limit))))
      return !(wr && (start < page_addr(32'(cfg_code_limit))));
    if (fits(start, stop, page_addr(32'(cfg_aux_page)), page_addr(32'(cfg_aux_page) + 32'd1)))
      return 1'b1;
    for (int i = 0; i < upac_pkg::STACK_SLOTS; i++) begin
      if (stack_slots_m[i].active && (stack_slots_m[i].first_page != '0)) begin
        lo = page_addr(32'(stack_slots_m[i].first_page));
        hi = page_addr(32'(stack_slots_m[i].first_page) + 32'(stack_slots_m[i].page_count));
        if (fits(start, stop, lo, hi)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 13) return $urandom_range(1, 3);
    if (r == 13) return $urandom_range(10, 40);
    burst_left = $urandom_range(20, 60);
    return 0;
  endfunction

  function automatic access_req_t random_req();
    access_req_t r;
    r.op               = 1'($urandom_range(0, 1));
    r.is_write         = 1'($urandom_range(0, 1));
    r.address          = $urandom;
    r.length           = $urandom;
    r.slot             = upac_pkg::SLOT_W'($urandom);
    r.slot_active      = 1'($urandom_range(0, 1));
    r.stack_first_page = upac_pkg::PAGE_W'($urandom);
    r.stack_page_count = upac_pkg::PAGE_W'($urandom);
    return r;
  endfunction

  // one transaction on the input channel, prediction at the accepting edge
  task automatic send_req(input access_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    op               <= r.op;
    is_write         <= r.is_write;
    address          <= r.address;
    length           <= r.length;
    slot             <= r.slot;
    slot_active      <= r.slot_active;
    stack_first_page <= r.stack_first_page;
    stack_page_count <= r.stack_page_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.op == upac_pkg::OP_TABLE) begin
      if (int'(r.slot) < upac_pkg::STACK_SLOTS)
        stack_slots_m[r.slot] = '{r.slot_active, r.stack_first_page, r.stack_page_count};
    end else begin
      allowed_q.push_back(predict_allowed(r.is_write, r.address, r.length));
    end
  endtask

  task automatic check_buf(input logic wr, input logic [31:0] a, input logic [31:0] len);
    access_req_t r;
    r          = random_req();
    r.op       = upac_pkg::OP_CHECK;
    r.is_write = wr;
    r.address  = a;
    r.length   = len;
    send_req(r);
  endtask

  task automatic load_slot(input logic [upac_pkg::SLOT_W-1:0] idx, input logic act,
                           input logic [upac_pkg::PAGE_W-1:0] first,
                           input logic [upac_pkg::PAGE_W-1:0] count);
    access_req_t r;
    r                  = random_req();
    r.op               = upac_pkg::OP_TABLE;
    r.slot             = idx;
    r.slot_active      = act;
    r.stack_first_page = first;
    r.stack_page_count = count;
    send_req(r);
  endtask

  function automatic access_req_t random_check();
    access_req_t r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] base;
    int          off;
    int          k;
    r    = random_req();
    r.op = upac_pkg::OP_CHECK;
    lo   = cfg_region_base;
    hi   = page_addr(32'(cfg_region_limit));
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: lo = page_addr(32'(cfg_code_limit));
      4, 5: begin
        lo = page_addr(32'(cfg_aux_page));
        hi = page_addr(32'(cfg_aux_page) + 32'd1);
      end
      6, 7: begin
        k  = $urandom_range(0, upac_pkg::STACK_SLOTS - 1);
        lo = page_addr(32'(stack_slots_m[k].first_page));
        hi = page_addr(32'(stack_slots_m[k].first_page) + 32'(stack_slots_m[k].page_count));
      end
      8: return r;
      default: begin
        // end lands just below, at or just past the 32-bit limit
        r.length = ~r.address + 32'($urandom_range(0, 2));
        return r;
      end
    endcase
    off       = int'($urandom_range(0, 12288)) - 6144;
    base      = $urandom_range(0, 1) ? lo : hi;
    r.address = base + 32'(off);
    case ($urandom_range(0, 3))
      0: r.length = hi - r.address + 32'($urandom_range(0, 2)) - 32'd1;
      1: r.length = 32'($urandom_range(0, 8192));
      2: r.length = 32'($urandom_range(0, 64));
      default: ;
    endcase
    return r;
  endfunction

  function automatic access_req_t random_slot_write();
    access_req_t r;
    r             = random_req();
    r.op          = upac_pkg::OP_TABLE;
    r.slot_active = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 4))
      0: r.stack_first_page = '0;
      1: r.stack_first_page = cfg_region_limit + upac_pkg::PAGE_W'($urandom_range(0, 40));
      2: r.stack_first_page = cfg_aux_page - upac_pkg::PAGE_W'($urandom_range(0, 8));
      3: r.stack_first_page = '1 - upac_pkg::PAGE_W'($urandom_range(0, 4));
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: r.stack_page_count = '0;
      1, 2: r.stack_page_count = upac_pkg::PAGE_W'($urandom_range(1, 16));
      default: ;
    endcase
    return r;
  endfunction

  task automatic put_reg(input upac_pkg::cfg_reg_t idx,
                         input logic [upac_pkg::ADDR_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // page registers get random upper bits, which the block must drop
  task automatic load_config(input logic [31:0] region_base, input logic [19:0] code_limit,
                             input logic [19:0] region_limit, input logic [19:0] aux_page);
    put_reg(upac_pkg::REG_USER_START, region_base);
    put_reg(upac_pkg::REG_CODE_END,   {12'($urandom), code_limit});
    put_reg(upac_pkg::REG_GLOBAL_END, {12'($urandom), region_limit});
    put_reg(upac_pkg::REG_AUX_PAGE,   {12'($urandom), aux_page});
    cfg_write        <= 1'b0;
    cfg_region_base  = region_base;
    cfg_code_limit   = code_limit;
    cfg_region_limit = region_limit;
    cfg_aux_page     = aux_page;
  endtask

  // table loads give no result, so wait out the pipe after the last check
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (allowed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_layout();
    check_buf(1'b0, 32'h0010_0000, 32'h0);
    check_buf(1'b1, 32'h0010_7FFF, 32'h1);
    check_buf(1'b1, 32'h0010_8000, 32'h1000);
    check_buf(1'b0, 32'h0011_3000, 32'h1000);
    check_buf(1'b0, 32'h0011_3000, 32'h1001);
    check_buf(1'b1, 32'h0012_C000, 32'h1000);
    check_buf(1'b0, 32'h000F_FFFF, 32'h2);
  endtask

  task automatic test_length_carry();
    check_buf(1'b0, 32'hFFFF_FFFF, 32'h1);
    check_buf(1'b0, 32'hFFFF_FFFF, 32'h0);
    check_buf(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    check_buf(1'b1, 32'h0010_9000, 32'hFFFF_FFFF);
  endtask

  task automatic test_stack_slots();
    load_slot(4'd0, 1'b1, 20'h00200, 20'd4);
    check_buf(1'b1, 32'h0020_0000, 32'h4000);
    check_buf(1'b0, 32'h0020_3FFF, 32'h2);
    // active slot with zero first page never matches
    load_slot(4'd15, 1'b1, 20'h00000, 20'd8);
    check_buf(1'b0, 32'h0000_0000, 32'h100);
    load_slot(4'd7, 1'b0, 20'h00300, 20'd1);
    check_buf(1'b0, 32'h0030_0000, 32'h10);
    // end page wraps past the top
    load_slot(4'd9, 1'b1, 20'hFFFFF, 20'hFFFFF);
    check_buf(1'b0, 32'hFFFF_F000, 32'h0);
    load_slot(4'd0, 1'b0, 20'h00200, 20'd4);
    check_buf(1'b1, 32'h0020_0000, 32'h10);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    load_config('0, '0, '0, '0);
    check_buf(1'b1, 32'h0, 32'h0);
    check_buf(1'b0, 32'h0, 32'h1);
    wait_idle();
    load_config('1, '1, '1, '1);
    check_buf(1'b0, 32'hFFFF_FFFF, 32'h0);
    check_buf(1'b1, 32'hFFFF_F000, 32'h10);
    wait_idle();
    load_config(upac_pkg::USER_START_RST, upac_pkg::CODE_END_RST,
                upac_pkg::GLOBAL_END_RST, upac_pkg::AUX_PAGE_RST);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    for (int n = 0; n < 80; n++) send_req(random_check());
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [19:0] base;
    logic [19:0] code_limit;
    logic [19:0] region_limit;
    logic [19:0] aux_page;
    logic [31:0] region_base;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      if (ph == 3) begin
        region_base  = $urandom;
        code_limit   = 20'($urandom);
        region_limit = 20'($urandom);
        aux_page     = 20'($urandom);
      end else begin
        base         = 20'($urandom);
        code_limit   = base + 20'($urandom_range(0, 16));
        region_limit = code_limit + 20'($urandom_range(0, 32));
        aux_page     = region_limit + 20'($urandom_range(0, 64));
        region_base  = {base, ($urandom_range(0, 1) ? 12'($urandom) : 12'h000)};
      end
      load_config(region_base, code_limit, region_limit, aux_page);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) send_req(random_slot_write());
        else send_req(random_check());
      end
    end
  endtask

  // receiver: mostly short stalls, some long ones, some stall-free stretches
  initial begin : receiver
    int stall_left;
    int free_left;
    int hold_left;
    int r;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 15);
        if (r < 9) begin
          out_stall <= 1'b0;
        end else if (r < 14) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else if (r == 14) begin
          stall_left = $urandom_range(15, 50);
          out_stall <= 1'b1;
        end else begin
          free_left = $urandom_range(20, 80);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (allowed_q.size() == 0) begin
        report_error($sformatf("result allowed=%b with no pending check", allowed));
      end else begin
        want = allowed_q.pop_front();
        if (allowed !== want)
          report_error($sformatf("allowed %b, predicted %b", allowed, want));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    foreach (stack_slots_m[i]) stack_slots_m[i] = '{1'b0, '0, '0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_layout();
    test_length_carry();
    test_stack_slots();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (allowed_q.size() != 0)
      report_error($sformatf("%0d checks never answered", allowed_q.size()));
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
